@@ rtl/core/upn_pkg.sv @@
// ----------------------------------------------------------------------------
// upn_pkg: shared types and constants for the up_n table evaluator
// Table geometry, channel payload structs, register indexes and the
// reciprocal constants used by the Horner steps of the sine/cosine series.
// ----------------------------------------------------------------------------
package upn_pkg;

    localparam int MAX_ROWS   = 32;
    localparam int MAX_TERMS  = 16;
    localparam int ROW_W      = $clog2(MAX_ROWS);
    localparam int TERM_W     = $clog2(MAX_TERMS);
    localparam int TAB_DEPTH  = MAX_ROWS * MAX_TERMS;
    localparam int TAB_ADDR_W = ROW_W + TERM_W;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ORDER  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TERM_COUNT = 2'd1;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_EVAL  = 1'b1;

    // shared multiplier geometry
    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = 34;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // iterative divider geometry
    localparam int DIV_N_W = 40;
    localparam int DIV_D_W = 6;

    localparam logic [33:0] PI_Q32 = 34'h3243F6A89;
    localparam int HORNER_STEPS = 6;
    localparam int ACC_W = 38;

    typedef struct packed {
        logic               operation;
        logic [5:0]         order;
        logic [4:0]         term_index;
        logic signed [31:0] coef_value;
        logic signed [31:0] x_point;
    } in_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic               status;
    } out_t;

    // floor(m/div) = (m * M) >> s, exact for m < 2^31; M = ceil(2^s/div)
    function automatic logic [31:0] horner_recip(input logic is_sin, input logic [2:0] step);
        logic [31:0] m;
        m = 32'd0;
        if (!is_sin) begin
            case (step)
                3'd0: m = 32'd4164816772; // 132
                3'd1: m = 32'd3054198967; // 90
                3'd2: m = 32'd2454267027; // 56
                3'd3: m = 32'd2290649225; // 30
                3'd4: m = 32'd2863311531; // 12
                3'd5: m = 32'd2147483648; // 2
                default: m = 32'd0;
            endcase
        end else begin
            case (step)
                3'd0: m = 32'd3524075731; // 156
                3'd1: m = 32'd2498890064; // 110
                3'd2: m = 32'd3817748708; // 72
                3'd3: m = 32'd3272356036; // 42
                3'd4: m = 32'd3435973837; // 20
                3'd5: m = 32'd2863311531; // 6
                default: m = 32'd0;
            endcase
        end
        return m;
    endfunction

    function automatic logic [5:0] horner_shift(input logic is_sin, input logic [2:0] step);
        logic [5:0] s;
        s = 6'd0;
        if (!is_sin) begin
            case (step)
                3'd0: s = 6'd39;
                3'd1: s = 6'd38;
                3'd2: s = 6'd37;
                3'd3: s = 6'd36;
                3'd4: s = 6'd35;
                3'd5: s = 6'd32;
                default: s = 6'd0;
            endcase
        end else begin
            case (step)
                3'd0: s = 6'd39;
                3'd1: s = 6'd38;
                3'd2: s = 6'd38;
                3'd3: s = 6'd37;
                3'd4: s = 6'd36;
                3'd5: s = 6'd34;
                default: s = 6'd0;
            endcase
        end
        return s;
    endfunction

endpackage

@@ rtl/core/upn_ram.sv @@
// ----------------------------------------------------------------------------
// upn_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle, read data registered.
// ----------------------------------------------------------------------------
module upn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/upn_mul.sv @@
// ----------------------------------------------------------------------------
// upn_mul: shared unsigned multiplier
// 32 x 34 bit product, registered; the result appears in the cycle after the operands.
// ----------------------------------------------------------------------------
module upn_mul import upn_pkg::*; (
    input  logic               aclk,
    input  logic [MUL_A_W-1:0] a,
    input  logic [MUL_B_W-1:0] b,
    output logic [MUL_P_W-1:0] p
);

    logic [MUL_P_W-1:0] p_reg;

    always_ff @(posedge aclk) begin
        p_reg <= MUL_P_W'(a) * MUL_P_W'(b);
    end

    assign p = p_reg;

endmodule

@@ rtl/core/upn_div.sv @@
// ----------------------------------------------------------------------------
// upn_div: iterative restoring divider
// One quotient bit per cycle over the DIV_N_W dividend bits; done pulses with results valid.
// ----------------------------------------------------------------------------
module upn_div import upn_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [DIV_N_W-1:0] dividend,
    input  logic [DIV_D_W-1:0] divisor,
    output logic               done,
    output logic [DIV_N_W-1:0] quot,
    output logic [DIV_D_W-1:0] rem
);

    localparam int CNT_W = $clog2(DIV_N_W + 1);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [DIV_N_W-1:0] quot_reg, quot_next;
    logic [DIV_D_W-1:0] rem_reg, rem_next;
    logic [DIV_D_W-1:0] dvs_reg, dvs_next;
    logic [DIV_D_W:0]   trial;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        trial     = {rem_reg, quot_reg[DIV_N_W-1]};
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIV_N_W);
            quot_next = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            if (trial >= {1'b0, dvs_reg}) begin
                rem_next  = DIV_D_W'(trial - {1'b0, dvs_reg});
                quot_next = {quot_reg[DIV_N_W-2:0], 1'b1};
            end else begin
                rem_next  = trial[DIV_D_W-1:0];
                quot_next = {quot_reg[DIV_N_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;
    assign rem  = rem_reg;

endmodule

@@ rtl/core/atomic_upn_table_eval.sv @@
// ----------------------------------------------------------------------------
// atomic_upn_table_eval: up_n(x) evaluator from a loaded Fourier table
// Coefficient writes go straight to the table; evaluations run a sequencer
// over one shared multiplier and one iterative divider.
// ----------------------------------------------------------------------------
//  channel   ports                        payload
//  input     s_valid / s_ready / s_data   in_t  (write or evaluate)
//  result    m_valid / m_ready / m_data   out_t (one per evaluate)
//  config    cfg_we / cfg_index / cfg_wdata
//
// A write transaction goes straight into the table. An evaluation that hits a range or
// support check skips the arithmetic; otherwise it runs two divides on the iterative
// divider and a Horner series for each term on the shared multiplier.
// Synchronous active-low reset; the table is not cleared. A stalled result
// sits in the output register while the next transaction is accepted.
// ----------------------------------------------------------------------------
module atomic_upn_table_eval import upn_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_t                   s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_t                  m_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_DIV1 = 4'd1;
    localparam logic [3:0] ST_ADV  = 4'd2;
    localparam logic [3:0] ST_RAD  = 4'd3;
    localparam logic [3:0] ST_R    = 4'd4;
    localparam logic [3:0] ST_R2   = 4'd5;
    localparam logic [3:0] ST_H1   = 4'd6;
    localparam logic [3:0] ST_H2   = 4'd7;
    localparam logic [3:0] ST_H3   = 4'd8;
    localparam logic [3:0] ST_SIN  = 4'd9;
    localparam logic [3:0] ST_SINR = 4'd10;
    localparam logic [3:0] ST_COEF = 4'd11;
    localparam logic [3:0] ST_ACC  = 4'd12;
    localparam logic [3:0] ST_FIN  = 4'd13;
    localparam logic [3:0] ST_DIV2 = 4'd14;
    localparam logic [3:0] ST_DONE = 4'd15;

    logic [3:0]  state_reg, state_next;
    logic [5:0]  max_order_reg, term_count_reg;
    logic        m_valid_reg, m_valid_next;
    out_t        m_data_reg, m_data_next;
    out_t        res_reg, res_next;

    logic [5:0]  n_reg, n_next;
    logic [5:0]  d_reg, d_next;
    logic [4:0]  terms_reg, terms_next;
    logic [4:0]  j_reg, j_next;
    logic [2:0]  i_reg, i_next;
    logic [31:0] q1_reg, q1_next;
    logic [5:0]  r1_reg, r1_next;
    logic [31:0] phase_reg, phase_next;
    logic [5:0]  prem_reg, prem_next;
    logic        cneg_reg, cneg_next;
    logic [31:0] cmag_reg, cmag_next;
    logic        sel_sin_reg, sel_sin_next;
    logic        sneg_reg, sneg_next;
    logic [30:0] r_reg, r_next;
    logic [30:0] r2_reg, r2_next;
    logic [31:0] t_reg, t_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;

    logic               accept;
    logic               tab_we;
    logic [TAB_ADDR_W-1:0] tab_waddr, tab_raddr;
    logic [31:0]        tab_rdata;
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [MUL_P_W-1:0] prod;
    logic               div_start, div_done;
    logic [DIV_N_W-1:0] div_dividend, div_quot;
    logic [DIV_D_W-1:0] div_rem;

    // rounded shifts of the product register
    logic [MUL_P_W-1:0] prod_h31, prod_h32;
    logic [31:0]        prod_r31, prod_r32;

    logic [31:0] x_abs;
    logic [31:0] x_lim;
    logic        ord_bad;
    logic [6:0]  rsum;
    logic [31:0] ph_sum;
    logic [29:0] frac, ang;
    logic [1:0]  quad;
    logic [30:0] hq;
    logic [31:0] term;
    logic [ACC_W-1:0] acc_mag;
    logic [DIV_N_W-1:0] q_fin;
    logic [31:0] val_fin;

    assign accept  = s_valid && s_ready;
    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign prod_h31 = prod + MUL_P_W'(64'h40000000);
    assign prod_h32 = prod + MUL_P_W'(64'h80000000);
    assign prod_r31 = prod_h31[62:31];
    assign prod_r32 = prod_h32[63:32];

    assign x_abs   = s_data.x_point[31] ? 32'(-s_data.x_point) : 32'(s_data.x_point);
    assign x_lim   = {7'(s_data.order) + 7'd2, 25'd0};
    assign ord_bad = (s_data.order == 6'd0) || (s_data.order > max_order_reg)
                     || (s_data.order > 6'(MAX_ROWS));

    assign tab_we    = accept && (s_data.operation == OP_WRITE)
                       && (s_data.order != 6'd0) && (s_data.order <= 6'(MAX_ROWS))
                       && (s_data.term_index != 5'd0)
                       && (s_data.term_index <= 5'(MAX_TERMS));
    assign tab_waddr = {ROW_W'(s_data.order - 6'd1), TERM_W'(s_data.term_index - 5'd1)};
    assign tab_raddr = {ROW_W'(n_reg - 6'd1), j_reg[TERM_W-1:0]};

    upn_ram #(.WIDTH(32), .DEPTH(TAB_DEPTH)) u_tab (
        .aclk  (aclk),
        .we    (tab_we),
        .waddr (tab_waddr),
        .wdata (s_data.coef_value),
        .raddr (tab_raddr),
        .rdata (tab_rdata)
    );

    upn_mul u_mul (
        .aclk (aclk),
        .a    (mul_a),
        .b    (mul_b),
        .p    (prod)
    );

    // divisor taken from d_next so the first divide sees the new order
    upn_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (d_next),
        .done     (div_done),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        res_next     = res_reg;
        n_next       = n_reg;
        d_next       = d_reg;
        terms_next   = terms_reg;
        j_next       = j_reg;
        i_next       = i_reg;
        q1_next      = q1_reg;
        r1_next      = r1_reg;
        phase_next   = phase_reg;
        prem_next    = prem_reg;
        cneg_next    = cneg_reg;
        cmag_next    = cmag_reg;
        sel_sin_next = sel_sin_reg;
        sneg_next    = sneg_reg;
        r_next       = r_reg;
        r2_next      = r2_reg;
        t_next       = t_reg;
        acc_next     = acc_reg;
        mul_a        = '0;
        mul_b        = '0;
        div_start    = 1'b0;
        div_dividend = '0;

        rsum    = {1'b0, prem_reg} + {1'b0, r1_reg};
        ph_sum  = phase_reg + q1_reg;
        quad    = phase_reg[31:30];
        frac    = phase_reg[29:0];
        ang     = (frac <= 30'h20000000) ? frac : 30'(31'h40000000 - {1'b0, frac});
        hq      = 31'(prod >> horner_shift(sel_sin_reg, i_reg));
        term    = prod_r31;
        acc_mag = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
        q_fin   = div_quot;
        val_fin = 32'd0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept && (s_data.operation == OP_EVAL)) begin
                    n_next     = s_data.order;
                    d_next     = s_data.order + 6'd2;
                    terms_next = (term_count_reg > 6'(MAX_TERMS)) ? 5'(MAX_TERMS)
                                                                  : term_count_reg[4:0];
                    if (ord_bad) begin
                        res_next.value  = '0;
                        res_next.status = 1'b1;
                        state_next      = ST_DONE;
                    end else if (x_abs >= x_lim) begin
                        res_next.value  = '0;
                        res_next.status = 1'b0;
                        state_next      = ST_DONE;
                    end else begin
                        div_start    = 1'b1;
                        div_dividend = {2'b00, x_abs, 6'd0};
                        state_next   = ST_DIV1;
                    end
                end
            end
            ST_DIV1: begin
                if (div_done) begin
                    q1_next    = div_quot[31:0];
                    r1_next    = div_rem;
                    phase_next = '0;
                    prem_next  = {1'b0, d_reg[5:1]};
                    j_next     = '0;
                    acc_next   = ACC_W'(32'h20000000);
                    state_next = (terms_reg == 5'd0) ? ST_FIN : ST_ADV;
                end
            end
            ST_ADV: begin
                // phase of term j+1 = phase of term j + q1, carrying the remainder
                if (rsum >= {1'b0, d_reg}) begin
                    prem_next  = 6'(rsum - {1'b0, d_reg});
                    phase_next = ph_sum + 32'd1;
                end else begin
                    prem_next  = rsum[5:0];
                    phase_next = ph_sum;
                end
                state_next = ST_RAD;
            end
            ST_RAD: begin
                cneg_next    = tab_rdata[31];
                cmag_next    = tab_rdata[31] ? 32'(-tab_rdata) : tab_rdata;
                sel_sin_next = (frac <= 30'h20000000) ? quad[0] : !quad[0];
                sneg_next    = (quad == 2'd1) || (quad == 2'd2);
                mul_a        = MUL_A_W'(ang);
                mul_b        = PI_Q32;
                state_next   = ST_R;
            end
            ST_R: begin
                r_next     = prod_r32[30:0];
                mul_a      = MUL_A_W'(prod_r32[30:0]);
                mul_b      = MUL_B_W'(prod_r32[30:0]);
                state_next = ST_R2;
            end
            ST_R2: begin
                r2_next    = prod_r31[30:0];
                t_next     = 32'h80000000;
                i_next     = '0;
                state_next = ST_H1;
            end
            ST_H1: begin
                mul_a      = MUL_A_W'(r2_reg);
                mul_b      = MUL_B_W'(t_reg);
                state_next = ST_H2;
            end
            ST_H2: begin
                mul_a      = MUL_A_W'(prod_r31[30:0]);
                mul_b      = MUL_B_W'(horner_recip(sel_sin_reg, i_reg));
                state_next = ST_H3;
            end
            ST_H3: begin
                t_next = 32'h80000000 - {1'b0, hq};
                i_next = i_reg + 3'd1;
                if (i_reg == 3'(HORNER_STEPS - 1)) begin
                    state_next = sel_sin_reg ? ST_SIN : ST_COEF;
                end else begin
                    state_next = ST_H1;
                end
            end
            ST_SIN: begin
                mul_a      = MUL_A_W'(r_reg);
                mul_b      = MUL_B_W'(t_reg);
                state_next = ST_SINR;
            end
            ST_SINR: begin
                t_next     = prod_r31;
                state_next = ST_COEF;
            end
            ST_COEF: begin
                mul_a      = cmag_reg;
                mul_b      = MUL_B_W'(t_reg);
                state_next = ST_ACC;
            end
            ST_ACC: begin
                if (cneg_reg != sneg_reg) begin
                    acc_next = acc_reg - ACC_W'(term);
                end else begin
                    acc_next = acc_reg + ACC_W'(term);
                end
                j_next     = j_reg + 5'd1;
                state_next = (j_reg + 5'd1 == terms_reg) ? ST_FIN : ST_ADV;
            end
            ST_FIN: begin
                div_start    = 1'b1;
                div_dividend = {1'b0, acc_mag, 1'b0} + DIV_N_W'(d_reg[5:1]);
                state_next   = ST_DIV2;
            end
            ST_DIV2: begin
                if (div_done) begin
                    if (acc_reg[ACC_W-1]) begin
                        val_fin = (q_fin > DIV_N_W'(64'h80000000)) ? 32'h80000000
                                                                    : 32'(-q_fin[31:0]);
                    end else begin
                        val_fin = (q_fin > DIV_N_W'(64'h7FFFFFFF)) ? 32'h7FFFFFFF
                                                                    : q_fin[31:0];
                    end
                    res_next.value  = val_fin;
                    res_next.status = 1'b0;
                    state_next      = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            m_valid_reg    <= 1'b0;
            max_order_reg  <= 6'd32;
            term_count_reg <= 6'd16;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                case (cfg_index)
                    CFG_MAX_ORDER:  max_order_reg  <= cfg_wdata;
                    CFG_TERM_COUNT: term_count_reg <= {1'b0, cfg_wdata[4:0]};
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg  <= m_data_next;
        res_reg     <= res_next;
        n_reg       <= n_next;
        d_reg       <= d_next;
        terms_reg   <= terms_next;
        j_reg       <= j_next;
        i_reg       <= i_next;
        q1_reg      <= q1_next;
        r1_reg      <= r1_next;
        phase_reg   <= phase_next;
        prem_reg    <= prem_next;
        cneg_reg    <= cneg_next;
        cmag_reg    <= cmag_next;
        sel_sin_reg <= sel_sin_next;
        sneg_reg    <= sneg_next;
        r_reg       <= r_next;
        r2_reg      <= r2_next;
        t_reg       <= t_next;
        acc_reg     <= acc_next;
    end

endmodule

@@ verif/atomic_upn_table_eval_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// atomic_upn_table_eval_test: self-checking bench for the up_n table evaluator
// Loads the whole coefficient table and then runs directed and random
// transactions under several register settings. A fixed-point predictor
// works out each expected result when the input transaction is accepted,
// and every output transaction is checked against the oldest expectation.
// ----------------------------------------------------------------------------
module atomic_upn_table_eval_test;
    import upn_pkg::*;

    localparam int IDLE_LIMIT = 20000;
    localparam int LONG_HOLD  = 3000;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    in_t                   s_data = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    out_t                  m_data;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_MAX_ORDER;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    atomic_upn_table_eval DUT (.*);

    always #5 aclk = ~aclk;

    // predictor state
    logic [31:0] coef_mirror [MAX_ROWS*MAX_TERMS];
    logic [5:0]  max_order_q = 6'd32;
    logic [4:0]  term_count_q = 5'd16;

    in_t  pend_q [$];
    out_t upn_expected [$];
    int   errors = 0;
    bit   s_fire = 0, m_fire = 0;
    bit   burst = 0;
    bit   hold_req = 0, hold_ack = 0;

    localparam longint unsigned ONE_Q31 = 64'h80000000;
    localparam longint unsigned COS_DIV [6] = '{132, 90, 56, 30, 12, 2};
    localparam longint unsigned SIN_DIV [6] = '{156, 110, 72, 42, 20, 6};

    function automatic longint unsigned q31_mul(longint unsigned a, longint unsigned b);
        return (a * b + 64'h40000000) >> 31;
    endfunction

    // Taylor series on a folded angle of at most an eighth of a turn
    function automatic longint unsigned taylor(longint unsigned f, bit want_sin);
        longint unsigned r, r2, t;
        r  = (f * longint'(PI_Q32) + 64'h80000000) >> 32;
        r2 = q31_mul(r, r);
        t  = ONE_Q31;
        for (int i = 0; i < 6; i++)
            t = ONE_Q31 - q31_mul(r2, t) / (want_sin ? SIN_DIV[i] : COS_DIV[i]);
        return want_sin ? q31_mul(r, t) : t;
    endfunction

    function automatic longint unsigned cos_mag(logic [31:0] ph, output bit neg);
        logic [1:0] quad;
        longint unsigned f, c, s;
        quad = ph[31:30];
        f = ph[29:0];
        if (f <= 64'h20000000) begin
            c = taylor(f, 0);
            s = taylor(f, 1);
        end else begin
            c = taylor(64'h40000000 - f, 1);
            s = taylor(64'h40000000 - f, 0);
        end
        neg = (quad == 2'd1 || quad == 2'd2);
        return quad[0] ? s : c;
    endfunction

    function automatic out_t upn_eval(logic [5:0] n, logic signed [31:0] x);
        out_t o;
        longint lim, acc, res, xs, trm;
        longint unsigned ax, d, cm, cmag, q;
        logic [31:0] craw, ph;
        bit sneg, cneg;
        int terms;
        o = '0;
        if (n < 1 || n > max_order_q || n > MAX_ROWS) begin
            o.status = 1'b1;
            return o;
        end
        xs  = x;
        lim = longint'(n + 2) * 64'h2000000;
        if (xs <= -lim || xs >= lim) return o;
        ax = xs < 0 ? -xs : xs;
        d = n + 2;
        terms = term_count_q < MAX_TERMS ? term_count_q : MAX_TERMS;
        acc = 64'h20000000;
        for (int j = 1; j <= terms; j++) begin
            craw = coef_mirror[(n - 1) * MAX_TERMS + (j - 1)];
            cneg = craw[31];
            cmag = cneg ? 64'h100000000 - craw : craw;
            ph = 32'((longint'(j) * ax * 64 + d / 2) / d);
            cm = cos_mag(ph, sneg);
            trm = q31_mul(cmag, cm);
            acc += (cneg != sneg) ? -trm : trm;
        end
        q = ((acc < 0 ? -acc * 2 : acc * 2) + d / 2) / d;
        res = acc < 0 ? -longint'(q) : longint'(q);
        if (res > 64'sd2147483647) res = 64'sd2147483647;
        if (res < -64'sd2147483648) res = -64'sd2147483648;
        o.value = res[31:0];
        return o;
    endfunction

    // sampling at the rising edge: predict, check, mirror registers, watchdog
    int idle_cycles = 0;
    always @(posedge aclk) begin
        out_t e;
        s_fire = s_valid && s_ready;
        m_fire = m_valid && m_ready;
        if (aresetn && cfg_we) begin
            if (cfg_index == CFG_MAX_ORDER) max_order_q = cfg_wdata;
            else if (cfg_index == CFG_TERM_COUNT) term_count_q = cfg_wdata[4:0];
        end
        if (s_fire) begin
            if (s_data.operation == OP_WRITE) begin
                if (s_data.order >= 1 && s_data.order <= MAX_ROWS &&
                    s_data.term_index >= 1 && s_data.term_index <= MAX_TERMS)
                    coef_mirror[(s_data.order - 1) * MAX_TERMS + s_data.term_index - 1] =
                        s_data.coef_value;
            end else
                upn_expected.push_back(upn_eval(s_data.order, s_data.x_point));
        end
        if (m_fire) begin
            if (upn_expected.size() == 0) begin
                errors++;
                $display("%0t: unexpected result transaction value=%0d status=%0d",
                         $time, m_data.value, m_data.status);
            end else begin
                e = upn_expected.pop_front();
                if (e.value !== m_data.value)
                    begin errors++; $display("%0t: value expected %0d got %0d",
                                             $time, e.value, m_data.value); end
                if (e.status !== m_data.status)
                    begin errors++; $display("%0t: status expected %0d got %0d",
                                             $time, e.status, m_data.status); end
            end
        end
        if (s_fire || m_fire || cfg_we || !aresetn) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // sender
    int s_gap = 0;
    always @(negedge aclk) begin
        logic nv;
        nv = s_valid;
        if (s_fire) begin
            nv = 1'b0;
            s_gap = burst ? 0 : $urandom_range(0, 14);
        end
        if (!nv) begin
            if (s_gap > 0) s_gap--;
            else if (pend_q.size() > 0) begin
                s_data <= pend_q.pop_front();
                nv = 1'b1;
            end
        end
        s_valid <= nv;
        s_fire = 0;
    end

    // receiver
    int m_wait = 0, m_hold = 0;
    always @(negedge aclk) begin
        if (hold_req != hold_ack) begin
            hold_ack = hold_req;
            m_hold = LONG_HOLD;
        end
        if (m_fire) m_wait = burst ? 0 : $urandom_range(0, 14);
        m_fire = 0;
        if (m_hold > 0) m_hold--;
        else if (m_wait > 0) m_wait--;
        m_ready <= (m_hold == 0 && m_wait == 0);
    end

    function automatic in_t wr_item(int n, int k, logic [31:0] c);
        in_t t;
        t = '0;
        t.operation = OP_WRITE; t.order = 6'(n); t.term_index = 5'(k); t.coef_value = c;
        t.x_point = $urandom;
        return t;
    endfunction

    function automatic in_t ev_item(int n, logic [31:0] x);
        in_t t;
        t = '0;
        t.operation = OP_EVAL; t.order = 6'(n); t.x_point = x;
        t.term_index = 5'($urandom); t.coef_value = $urandom;
        return t;
    endfunction

    function automatic in_t rand_item();
        int sel, n;
        logic [31:0] m;
        sel = $urandom_range(0, 19);
        n = $urandom_range(1, 32);
        m = $urandom_range(0, (n + 2) * 32'h2000000);
        if (sel < 8) return wr_item(n, $urandom_range(1, 16), $urandom);
        if (sel == 8) return wr_item($urandom_range(0, 63), $urandom_range(0, 31), $urandom);
        if (sel == 9) return ev_item($urandom_range(0, 63), $urandom);
        return ev_item(n, $urandom_range(0, 1) ? -m : m);
    endfunction

    task automatic quiesce();
        wait (pend_q.size() == 0 && !s_valid && upn_expected.size() == 0);
        repeat (20) @(negedge aclk);
    endtask

    task automatic reg_write(logic [CFG_IDX_W-1:0] idx, int v);
        @(negedge aclk);
        cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= CFG_DATA_W'(v);
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    initial begin
        int mo [7] = '{32, 1, 32, 63, 0, 17, 32};
        int tc [7] = '{16, 1, 0, 31, 4, 8, 16};
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        // every entry is written before anything reads it
        for (int i = 1; i <= MAX_ROWS; i++)
            for (int k = 1; k <= MAX_TERMS; k++)
                pend_q.push_back(wr_item(i, k, $urandom));
        // directed: extreme coefficients, ignored writes, range and support edges
        pend_q.push_back(wr_item(1, 1, 32'h80000000));
        pend_q.push_back(wr_item(1, 2, 32'h7FFFFFFF));
        pend_q.push_back(wr_item(32, 16, 32'h80000000));
        pend_q.push_back(wr_item(0, 3, 32'h12345678));
        pend_q.push_back(wr_item(63, 31, 32'hFFFFFFFF));
        pend_q.push_back(wr_item(5, 0, 32'h0));
        pend_q.push_back(wr_item(5, 17, 32'h0));
        pend_q.push_back(ev_item(0, 32'h0));
        pend_q.push_back(ev_item(33, 32'h0));
        pend_q.push_back(ev_item(63, 32'hFFFFFFFF));
        pend_q.push_back(ev_item(1, 32'h0));
        pend_q.push_back(ev_item(1, 3 * 32'h2000000 - 1));
        pend_q.push_back(ev_item(1, 3 * 32'h2000000));
        pend_q.push_back(ev_item(1, -(3 * 32'h2000000)));
        pend_q.push_back(ev_item(1, -(3 * 32'h2000000) + 1));
        pend_q.push_back(ev_item(32, 32'h7FFFFFFF));
        pend_q.push_back(ev_item(32, 32'h80000000));
        pend_q.push_back(ev_item(32, 34 * 32'h2000000 - 1));
        pend_q.push_back(ev_item(32, 32'h00000001));
        for (int p = 0; p < 7; p++) begin
            quiesce();
            reg_write(CFG_MAX_ORDER, mo[p]);
            reg_write(CFG_TERM_COUNT, tc[p]);
            burst = (p % 3 == 1);
            if (p == 1) begin
                // short evaluations while the receiver holds off, so the input stalls
                hold_req = ~hold_req;
                for (int i = 0; i < 20; i++) pend_q.push_back(ev_item(1, $urandom));
            end
            pend_q.push_back(ev_item(mo[p] == 0 ? 1 : mo[p], 32'h0));
            for (int i = 0; i < 90; i++) pend_q.push_back(rand_item());
        end
        quiesce();
        repeat (600) @(negedge aclk);
        if (errors == 0 && upn_expected.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/upn_pkg.sv
rtl/core/upn_ram.sv
rtl/core/upn_mul.sv
rtl/core/upn_div.sv
rtl/core/atomic_upn_table_eval.sv
verif/atomic_upn_table_eval_test.sv
